### rtl/ialu_pkg.sv
package ialu_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned ShamtW = 5;
	localparam int unsigned CmdW = 4;
	// One divider stage per quotient bit
	localparam int unsigned DivSteps = DataW;

	// Command codes
	localparam logic [CmdW-1:0] CMD_ADD  = 4'd0;
	localparam logic [CmdW-1:0] CMD_SUB  = 4'd1;
	localparam logic [CmdW-1:0] CMD_AND  = 4'd2;
	localparam logic [CmdW-1:0] CMD_OR   = 4'd3;
	localparam logic [CmdW-1:0] CMD_XOR  = 4'd4;
	localparam logic [CmdW-1:0] CMD_MUL  = 4'd5;
	localparam logic [CmdW-1:0] CMD_DIV  = 4'd6;
	localparam logic [CmdW-1:0] CMD_SHL  = 4'd7;
	localparam logic [CmdW-1:0] CMD_SHR  = 4'd8;
	localparam logic [CmdW-1:0] CMD_SHRA = 4'd9;

	// State carried by one stage of the divide pipeline
	typedef struct packed {
		logic [CmdW-1:0]  cmd;
		logic [DataW-1:0] res;   // non-divide result, computed up front
		logic             neg;   // quotient sign
		logic             dz;    // zero divisor
		logic [DataW-1:0] rem;   // partial remainder
		logic [DataW-1:0] quo;   // dividend bits shifting out, quotient bits in
		logic [DataW-1:0] dvs;   // divisor magnitude
	} div_stage_t;

endpackage

### rtl/integer_alu_32.sv
// integer_alu_32: pipelined 32-bit integer ALU.
//
// Input channel: in_valid / in_stall carry command, operand_a, operand_b.
// Output channel: out_valid / out_stall carry result_value, divide_error.
// A transaction happens on a rising edge with valid high and stall low.
//
// Every command takes the same path: an input register, an operate stage
// (add, sub, logic, multiply, shifts, divide setup), 32 restoring divide
// stages that each produce one quotient bit, and an output register.
// All commands take the same path, so results leave in order. Throughput
// is one transaction per cycle while out_stall does not hold a result; the
// 32-stage divider is fully pipelined.
//
// Divide by zero returns all ones with divide_error set. Unused command
// codes return zero.
//
// Reset (arst_n low) clears all valid bits; in-flight transactions are
// dropped. When out_stall holds a valid result, the whole pipeline freezes
// and in_stall is raised in the same cycle, so nothing is lost or repeated.
module integer_alu_32 (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ialu_pkg::CmdW-1:0]  command,
	input  logic [ialu_pkg::DataW-1:0] operand_a,
	input  logic [ialu_pkg::DataW-1:0] operand_b,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ialu_pkg::DataW-1:0] result_value,
	output logic                       divide_error
);
	import ialu_pkg::*;

	logic                 adv;
	logic                 vld_s1;
	logic [CmdW-1:0]      cmd_s1;
	logic [DataW-1:0]     a_s1;
	logic [DataW-1:0]     b_s1;
	logic [DataW-1:0]     simple_res;
	logic [DataW-1:0]     mul_full;
	logic [ShamtW-1:0]    shamt;
	div_stage_t           prep;
	div_stage_t           stg_s [0:DivSteps];
	logic                 vld_s [0:DivSteps];
	div_stage_t           last;
	logic [DataW-1:0]     fin_res;
	logic                 fin_err;

	// Global advance: freeze only when a result is held by the receiver
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= command;
			a_s1   <= operand_a;
			b_s1   <= operand_b;
		end
	end

	// Operate stage: everything but the divide finishes here
	assign shamt    = b_s1[ShamtW-1:0];
	assign mul_full = a_s1 * b_s1;

	always_comb begin
		case (cmd_s1)
			CMD_ADD:  simple_res = a_s1 + b_s1;
			CMD_SUB:  simple_res = a_s1 - b_s1;
			CMD_AND:  simple_res = a_s1 & b_s1;
			CMD_OR:   simple_res = a_s1 | b_s1;
			CMD_XOR:  simple_res = a_s1 ^ b_s1;
			CMD_MUL:  simple_res = mul_full;
			CMD_SHL:  simple_res = a_s1 << shamt;
			CMD_SHR:  simple_res = a_s1 >> shamt;
			CMD_SHRA: simple_res = DataW'($signed(a_s1) >>> shamt);
			default:  simple_res = '0;
		endcase
	end

	// Divide setup: magnitudes and sign
	always_comb begin
		prep.cmd = cmd_s1;
		prep.res = simple_res;
		prep.neg = a_s1[DataW-1] ^ b_s1[DataW-1];
		prep.dz  = (b_s1 == '0);
		prep.rem = '0;
		prep.quo = a_s1[DataW-1] ? (DataW'(0) - a_s1) : a_s1;
		prep.dvs = b_s1[DataW-1] ? (DataW'(0) - b_s1) : b_s1;
	end

	// Valid bits of the operate stage and the divide stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DivSteps; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= vld_s1;
			for (int k = 0; k < DivSteps; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	// Restoring divide, one quotient bit per stage
	always_ff @(posedge clk) begin
		logic [DataW:0] trial;
		logic [DataW:0] shifted;
		div_stage_t     nxt;
		if (adv) begin
			stg_s[0] <= prep;
			for (int k = 0; k < DivSteps; k++) begin
				shifted = {stg_s[k].rem, stg_s[k].quo[DataW-1]};
				trial   = shifted - {1'b0, stg_s[k].dvs};
				nxt     = stg_s[k];
				if (!trial[DataW]) begin
					nxt.rem = trial[DataW-1:0];
					nxt.quo = {stg_s[k].quo[DataW-2:0], 1'b1};
				end else begin
					nxt.rem = shifted[DataW-1:0];
					nxt.quo = {stg_s[k].quo[DataW-2:0], 1'b0};
				end
				stg_s[k+1] <= nxt;
			end
		end
	end

	// Final select: sign fix and zero-divisor handling
	assign last = stg_s[DivSteps];

	always_comb begin
		if (last.cmd == CMD_DIV) begin
			fin_err = last.dz;
			if (last.dz) begin
				fin_res = '1;
			end else if (last.neg) begin
				fin_res = DataW'(0) - last.quo;
			end else begin
				fin_res = last.quo;
			end
		end else begin
			fin_err = 1'b0;
			fin_res = last.res;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s[DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_value <= fin_res;
			divide_error <= fin_err;
		end
	end

	// A zero-divisor result is always all ones
	a_err_ones: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_error |-> result_value == '1)
		else $error("divide_error without all-ones result");

	// A frozen pipeline keeps the input, first-stage and last-stage valid bits
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s1) && $stable(vld_s[DivSteps]) && $stable(vld_s[0]))
		else $error("valid bits moved while stalled");

	// The last divide stage reaches the output when the pipeline advances
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s[DivSteps] |=> out_valid)
		else $error("result lost at output register");

	// A stalled input means a held, stable result blocks the output, or the stall just rose
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall && $stable(result_value) || $rose(in_stall))
		else $error("input stalled without a held result");

endmodule
